[rtl/tcpse_pkg.sv]
package tcpse_pkg;

    typedef enum logic [1:0] {
        CMD_RECEIVE    = 2'd0,
        CMD_LISTEN     = 2'd1,
        CMD_CONNECT    = 2'd2,
        CMD_DISCONNECT = 2'd3
    } cmd_e_t;

    typedef enum logic [2:0] {
        ST_CLOSED     = 3'd0,
        ST_LISTEN     = 3'd1,
        ST_SYN_SENT   = 3'd2,
        ST_SYN_RCVD   = 3'd3,
        ST_ESTAB      = 3'd4,
        ST_CLOSE_WAIT = 3'd5,
        ST_FIN_WAIT1  = 3'd6,
        ST_FIN_WAIT2  = 3'd7
    } conn_state_t;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_RESET    = 2'd1,
        STS_NO_MATCH = 2'd2,
        STS_FULL     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_PROC,
        S_OUT0,
        S_OUT1
    } fsm_t;

    localparam logic [1:0] CFG_LOCAL_ADDRESS    = 2'd0;
    localparam logic [1:0] CFG_INITIAL_SEQUENCE = 2'd1;
    localparam logic [1:0] CFG_FIRST_PORT       = 2'd2;

    localparam logic [31:0] LOCAL_ADDRESS_RESET = 32'h0000_0000;
    localparam logic [31:0] INIT_SEQ_RESET      = 32'hBEEF_CAFE;
    localparam logic [15:0] FIRST_PORT_RESET    = 16'd1024;
    localparam logic [15:0] MIN_SEG_SIZE        = 16'd20;

    localparam logic [7:0] FL_FIN = 8'h01;
    localparam logic [7:0] FL_SYN = 8'h02;
    localparam logic [7:0] FL_RST = 8'h04;
    localparam logic [7:0] FL_ACK = 8'h10;

    typedef struct packed {
        cmd_e_t      command;
        logic [31:0] peer_ip;
        logic [31:0] dest_ip;
        logic [15:0] peer_port;
        logic [15:0] own_port;
        logic [7:0]  seg_flags;
        logic [31:0] seg_sequence;
        logic [15:0] seg_size;
        logic [3:0]  header_words;
        logic        payload_accepted;
        logic [3:0]  socket_index;
    } cmd_item_t;

    typedef struct packed {
        status_t     status;
        logic        tx_valid;
        logic [7:0]  tx_flags;
        logic [31:0] tx_sequence;
        logic [31:0] tx_acknowledge;
        logic [15:0] tx_own_port;
        logic [15:0] tx_peer_port;
        logic [31:0] tx_peer_ip;
        logic [3:0]  entry_index;
        logic        deliver;
        logic        last;
    } res_item_t;

    typedef struct packed {
        conn_state_t state;
        logic [31:0] own_ip;
        logic [15:0] own_port;
        logic [31:0] peer_ip;
        logic [15:0] peer_port;
        logic [31:0] snd;
        logic [31:0] ack;
    } entry_t;

    function automatic res_item_t make_result(status_t sts, logic txv, logic [7:0] fl,
                                              entry_t e, logic [3:0] idx, logic dlv);
        res_item_t r;
        r = '0;
        r.status      = sts;
        r.entry_index = idx;
        r.deliver     = dlv;
        if (txv)
        begin
            r.tx_valid       = 1'b1;
            r.tx_flags       = fl;
            r.tx_sequence    = e.snd;
            r.tx_acknowledge = e.ack;
            r.tx_own_port    = e.own_port;
            r.tx_peer_port   = e.peer_port;
            r.tx_peer_ip     = e.peer_ip;
        end
        return r;
    endfunction

endpackage

[rtl/tcpse_if.sv]
interface tcpse_cmd_if import tcpse_pkg::*; ();
    logic      valid;
    logic      ready;
    cmd_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tcpse_res_if import tcpse_pkg::*; ();
    logic      valid;
    logic      ready;
    res_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tcpse_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/tcp_connection_state_engine.sv]
// Flow: a receive item scans the entry memory linearly (one table entry read per cycle),
// a listen/connect item scans the valid bits for a free entry, a disconnect reads its own.
// One item at a time: a new item is taken only after the last result of the previous one
// has been accepted by the result side.
// Reset: all entries free, control and configuration registers at their defaults, next ephemeral port 1024.
module tcp_connection_state_engine import tcpse_pkg::*; #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    tcpse_cmd_if.sink   cmd,
    tcpse_res_if.source res,
    tcpse_cfg_if.sink   cfg
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IW:0] DEPTH_W = (IW+1)'(TABLE_DEPTH);
    localparam logic [IW+3:0] DEPTH_X = (IW+4)'(TABLE_DEPTH);

    fsm_t                   state_reg, state_next;
    cmd_item_t              item_reg, item_next;
    logic [IW:0]            scan_reg, scan_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]          cmp_idx_reg, cmp_idx_next;
    logic [IW-1:0]          idx_reg, idx_next;
    logic                   found_reg, found_next;
    entry_t                 entry_reg, entry_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [15:0]            port_reg, port_next;
    res_item_t              res0_reg, res0_next;
    res_item_t              res1_reg, res1_next;
    logic                   two_reg, two_next;
    logic [31:0]            local_addr_reg;
    logic [31:0]            init_seq_reg;

    entry_t        table_mem [TABLE_DEPTH];
    entry_t        mem_q;
    logic [IW-1:0] mem_raddr;
    logic          mem_we;

    logic [IW-1:0] scan_idx;
    logic [IW+3:0] sock_wide;
    logic [IW+3:0] idx_wide;
    logic [IW-1:0] d_idx;
    logic          d_in_range;
    logic [3:0]    idx4;
    logic          bare_syn;
    logic          hit;

    // processing results
    entry_t      ent, snap0, snap1;
    logic [7:0]  fl0, fl1;
    logic        dlv0, rst_req, data_seg, short_seg;
    logic [1:0]  n_res;
    logic [15:0] hlen16;
    logic        pr_we, pr_set, pr_clr, pr_port_inc;
    res_item_t   pr_res0, pr_res1;

    assign scan_idx   = scan_reg[IW-1:0];
    assign sock_wide  = {{IW{1'b0}}, item_reg.socket_index};
    assign d_in_range = sock_wide < DEPTH_X;
    assign d_idx      = sock_wide[IW-1:0];
    assign idx_wide   = {4'b0000, idx_reg};
    assign idx4       = idx_wide[3:0];
    assign bare_syn   = (item_reg.seg_flags & (FL_SYN | FL_ACK)) == FL_SYN;
    assign hlen16     = {10'd0, item_reg.header_words, 2'b00};
    assign short_seg  = (item_reg.seg_size < MIN_SEG_SIZE) || (hlen16 > item_reg.seg_size);

    assign hit = valid_reg[cmp_idx_reg]
              && mem_q.own_port == item_reg.own_port
              && mem_q.own_ip == item_reg.dest_ip
              && ((mem_q.state == ST_LISTEN && bare_syn)
                  || (mem_q.peer_port == item_reg.peer_port
                      && mem_q.peer_ip == item_reg.peer_ip));

    assign mem_raddr = (item_reg.command == CMD_DISCONNECT) ? d_idx : scan_idx;
    assign mem_we    = (state_reg == S_PROC) && pr_we;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[idx_reg] <= ent;
        end
        mem_q <= table_mem[mem_raddr];
    end

    // item processing on the fetched entry
    always_comb
    begin
        ent         = entry_reg;
        snap0       = entry_reg;
        snap1       = entry_reg;
        fl0         = '0;
        fl1         = '0;
        dlv0        = 1'b0;
        rst_req     = 1'b0;
        data_seg    = 1'b0;
        n_res       = 2'd0;
        pr_we       = 1'b0;
        pr_set      = 1'b0;
        pr_clr      = 1'b0;
        pr_port_inc = 1'b0;
        pr_res0     = make_result(STS_NO_MATCH, 1'b0, 8'h00, entry_reg, 4'd0, 1'b0);
        pr_res1     = pr_res0;
        case (item_reg.command)
            CMD_RECEIVE:
            begin
                if (!short_seg && found_reg)
                begin
                    if ((item_reg.seg_flags & FL_RST) != 8'h00)
                    begin
                        ent.state = ST_CLOSED;
                    end
                    else
                    begin
                        case (item_reg.seg_flags & (FL_SYN | FL_ACK | FL_FIN))
                            FL_SYN:
                            begin
                                if (entry_reg.state == ST_LISTEN)
                                begin
                                    ent.state     = ST_SYN_RCVD;
                                    ent.peer_port = item_reg.peer_port;
                                    ent.peer_ip   = item_reg.peer_ip;
                                    ent.ack       = item_reg.seg_sequence + 32'd1;
                                    ent.snd       = init_seq_reg;
                                    snap0         = ent;
                                    fl0           = FL_SYN | FL_ACK;
                                    n_res         = 2'd1;
                                    ent.snd       = init_seq_reg + 32'd1;
                                end
                                else
                                begin
                                    rst_req = 1'b1;
                                end
                            end
                            FL_SYN | FL_ACK:
                            begin
                                if (entry_reg.state == ST_SYN_SENT)
                                begin
                                    ent.state = ST_ESTAB;
                                    ent.ack   = item_reg.seg_sequence + 32'd1;
                                    ent.snd   = entry_reg.snd + 32'd1;
                                    snap0     = ent;
                                    fl0       = FL_ACK;
                                    n_res     = 2'd1;
                                end
                                else
                                begin
                                    rst_req = 1'b1;
                                end
                            end
                            FL_SYN | FL_FIN, FL_SYN | FL_FIN | FL_ACK:
                            begin
                                rst_req = 1'b1;
                            end
                            FL_FIN, FL_FIN | FL_ACK:
                            begin
                                if (entry_reg.state == ST_ESTAB)
                                begin
                                    ent.state = ST_CLOSE_WAIT;
                                    ent.ack   = entry_reg.ack + 32'd1;
                                    snap0     = ent;
                                    snap1     = ent;
                                    fl0       = FL_ACK;
                                    fl1       = FL_FIN | FL_ACK;
                                    n_res     = 2'd2;
                                end
                                else if (entry_reg.state == ST_CLOSE_WAIT)
                                begin
                                    ent.state = ST_CLOSED;
                                end
                                else if (entry_reg.state == ST_FIN_WAIT1
                                         || entry_reg.state == ST_FIN_WAIT2)
                                begin
                                    ent.state = ST_CLOSED;
                                    ent.ack   = entry_reg.ack + 32'd1;
                                    snap0     = ent;
                                    fl0       = FL_ACK;
                                    n_res     = 2'd1;
                                end
                                else
                                begin
                                    rst_req = 1'b1;
                                end
                            end
                            FL_ACK:
                            begin
                                if (entry_reg.state == ST_SYN_RCVD)
                                begin
                                    ent.state = ST_ESTAB;
                                end
                                else if (entry_reg.state == ST_FIN_WAIT1)
                                begin
                                    ent.state = ST_FIN_WAIT2;
                                end
                                else if (entry_reg.state == ST_CLOSE_WAIT)
                                begin
                                    ent.state = ST_CLOSED;
                                end
                                else if (item_reg.seg_flags != FL_ACK)
                                begin
                                    data_seg = 1'b1;
                                end
                            end
                            default:
                            begin
                                data_seg = 1'b1;
                            end
                        endcase
                    end
                    if (data_seg)
                    begin
                        if (item_reg.seg_sequence == entry_reg.ack && item_reg.payload_accepted)
                        begin
                            ent.ack = entry_reg.ack
                                    + {16'd0, item_reg.seg_size - hlen16};
                            snap0   = ent;
                            fl0     = FL_ACK;
                            dlv0    = 1'b1;
                            n_res   = 2'd1;
                        end
                        else
                        begin
                            rst_req = 1'b1;
                        end
                    end
                    if (rst_req)
                    begin
                        pr_res0 = make_result(STS_RESET, 1'b0, 8'h00, ent, idx4, 1'b0);
                        n_res   = 2'd1;
                    end
                    else
                    begin
                        pr_we   = 1'b1;
                        pr_clr  = (ent.state == ST_CLOSED);
                        pr_res0 = make_result(STS_OK, n_res != 2'd0, fl0, snap0, idx4, dlv0);
                        pr_res1 = make_result(STS_OK, 1'b1, fl1, snap1, idx4, 1'b0);
                    end
                end
            end
            CMD_LISTEN, CMD_CONNECT:
            begin
                if (!found_reg)
                begin
                    pr_res0 = make_result(STS_FULL, 1'b0, 8'h00, ent, 4'd0, 1'b0);
                end
                else
                begin
                    pr_we      = 1'b1;
                    pr_set     = 1'b1;
                    ent.own_ip = local_addr_reg;
                    ent.ack    = '0;
                    if (item_reg.command == CMD_LISTEN)
                    begin
                        ent.state     = ST_LISTEN;
                        ent.own_port  = item_reg.own_port;
                        ent.peer_ip   = '0;
                        ent.peer_port = '0;
                        ent.snd       = '0;
                        pr_res0 = make_result(STS_OK, 1'b0, 8'h00, ent, idx4, 1'b0);
                    end
                    else
                    begin
                        ent.state     = ST_SYN_SENT;
                        ent.own_port  = port_reg;
                        ent.peer_ip   = item_reg.peer_ip;
                        ent.peer_port = item_reg.peer_port;
                        ent.snd       = init_seq_reg;
                        pr_port_inc   = 1'b1;
                        pr_res0 = make_result(STS_OK, 1'b1, FL_SYN, ent, idx4, 1'b0);
                    end
                end
            end
            default:
            begin
                if (!found_reg)
                begin
                    pr_res0 = make_result(STS_NO_MATCH, 1'b0, 8'h00, ent,
                                          d_in_range ? idx4 : 4'd0, 1'b0);
                end
                else if (entry_reg.state == ST_LISTEN)
                begin
                    pr_clr  = 1'b1;
                    pr_res0 = make_result(STS_OK, 1'b0, 8'h00, ent, idx4, 1'b0);
                end
                else
                begin
                    ent.state = ST_FIN_WAIT1;
                    pr_res0   = make_result(STS_OK, 1'b1, FL_FIN | FL_ACK, ent, idx4, 1'b0);
                    ent.snd   = entry_reg.snd + 32'd1;
                    pr_we     = 1'b1;
                end
            end
        endcase
    end

    // sequencer: next state and handshake outputs
    always_comb
    begin
        state_next   = state_reg;
        item_next    = item_reg;
        scan_next    = scan_reg;
        cmp_vld_next = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        idx_next     = idx_reg;
        found_next   = found_reg;
        entry_next   = entry_reg;
        valid_next   = valid_reg;
        port_next    = port_reg;
        res0_next    = res0_reg;
        res1_next    = res1_reg;
        two_next     = two_reg;
        cmd.ready    = 1'b0;
        res.valid    = 1'b0;
        res.data     = res0_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                begin
                    item_next  = cmd.data;
                    scan_next  = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                case (item_reg.command)
                    CMD_DISCONNECT:
                    begin
                        state_next = S_FETCH;
                    end
                    CMD_LISTEN, CMD_CONNECT:
                    begin
                        if (scan_reg == DEPTH_W)
                        begin
                            found_next = 1'b0;
                            state_next = S_PROC;
                        end
                        else if (!valid_reg[scan_idx])
                        begin
                            found_next = 1'b1;
                            idx_next   = scan_idx;
                            state_next = S_PROC;
                        end
                        else
                        begin
                            scan_next = scan_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                        // compare the entry read last cycle while the next one is read
                        if (cmp_vld_reg && hit)
                        begin
                            found_next = 1'b1;
                            idx_next   = cmp_idx_reg;
                            entry_next = mem_q;
                            state_next = S_PROC;
                        end
                        else if (scan_reg == DEPTH_W)
                        begin
                            if (!cmp_vld_reg)
                            begin
                                found_next = 1'b0;
                                state_next = S_PROC;
                            end
                        end
                        else
                        begin
                            cmp_vld_next = 1'b1;
                            cmp_idx_next = scan_idx;
                            scan_next    = scan_reg + 1'b1;
                        end
                    end
                endcase
            end
            S_FETCH:
            begin
                entry_next = mem_q;
                idx_next   = d_idx;
                found_next = d_in_range && valid_reg[d_idx];
                state_next = S_PROC;
            end
            S_PROC:
            begin
                if (pr_set)
                begin
                    valid_next[idx_reg] = 1'b1;
                end
                if (pr_clr)
                begin
                    valid_next[idx_reg] = 1'b0;
                end
                if (pr_port_inc)
                begin
                    port_next = port_reg + 16'd1;
                end
                res0_next      = pr_res0;
                res0_next.last = (n_res != 2'd2);
                res1_next      = pr_res1;
                res1_next.last = 1'b1;
                two_next       = (n_res == 2'd2);
                state_next     = S_OUT0;
            end
            S_OUT0:
            begin
                res.valid = 1'b1;
                res.data  = res0_reg;
                if (res.ready)
                begin
                    state_next = two_reg ? S_OUT1 : S_IDLE;
                end
            end
            S_OUT1:
            begin
                res.valid = 1'b1;
                res.data  = res1_reg;
                if (res.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign cfg.ready = 1'b1;

    // a write to the first ephemeral port setting is ignored; the counter always starts at
    // FIRST_PORT_RESET after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            scan_reg       <= '0;
            cmp_vld_reg    <= 1'b0;
            found_reg      <= 1'b0;
            valid_reg      <= '0;
            port_reg       <= FIRST_PORT_RESET;
            two_reg        <= 1'b0;
            local_addr_reg <= LOCAL_ADDRESS_RESET;
            init_seq_reg   <= INIT_SEQ_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            scan_reg    <= scan_next;
            cmp_vld_reg <= cmp_vld_next;
            found_reg   <= found_next;
            valid_reg   <= valid_next;
            port_reg    <= port_next;
            two_reg     <= two_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_LOCAL_ADDRESS:    local_addr_reg <= cfg.data;
                    CFG_INITIAL_SEQUENCE: init_seq_reg   <= cfg.data;
                    default:              ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        cmp_idx_reg <= cmp_idx_next;
        idx_reg     <= idx_next;
        entry_reg   <= entry_next;
        res0_reg    <= res0_next;
        res1_reg    <= res1_next;
    end

endmodule
